// ===== design/block_request_ring_merger_core_defines.svh =====
// assertion macros for the request ring merger core
// used by block_request_ring_merger_core.sv; no other dependencies
`ifndef BLOCK_REQUEST_RING_MERGER_CORE_DEFINES_SVH
`define BLOCK_REQUEST_RING_MERGER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/brm_pkg.sv =====
// shared types and codes for the request ring merger core
// no dependencies
package brm_pkg;

    typedef enum logic [1:0] {
        REQ_SUBMIT  = 2'd0,
        REQ_CONSUME = 2'd1,
        REQ_PUBLISH = 2'd2,
        REQ_RESET   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_MERGED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_CLOSED  = 3'd3,
        ST_BAD_SEG = 3'd4
    } t_status;

    localparam logic [1:0] LINK_ACTIVE    = 2'd0;
    localparam logic [1:0] LINK_SUSPENDED = 2'd1;
    localparam logic [1:0] LINK_CLOSED    = 2'd2;

    localparam logic       REG_LINK_STATE     = 1'b0;
    localparam logic       REG_PARTITION_BITS = 1'b1;

    localparam logic [3:0] PBITS_RESET = 4'd4;
    localparam logic [8:0] SECT_MASK   = 9'h1FF;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        logic [3:0]  segment_index;
        logic [31:0] segment_word;
        logic [31:0] entry_id;
        logic        entry_is_write;
        logic [31:0] entry_sector;
        logic [15:0] entry_device;
        logic [31:0] published_index;
        logic        kick;
    } t_result;

endpackage

// ===== design/block_request_ring_merger_core.sv =====
// request ring producer with contiguous segment merging
// depends on brm_pkg and block_request_ring_merger_core_defines.svh
// accepted beats (one per cycle while o_in_stall is low) give registered result beats
// the run and index registers update in the accept cycle
// a two-deep output buffer takes one more input beat while a result beat is stalled
// reset (synchronous, active low): indices and run cleared, link suspended, partition bits 4
`include "block_request_ring_merger_core_defines.svh"

module block_request_ring_merger_core #(
    parameter int RING_SIZE    = 64,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_is_write,
    input  logic [15:0] i_device,
    input  logic [31:0] i_sector,
    input  logic [8:0]  i_sector_count,
    input  logic [31:0] i_buffer_addr,
    input  logic [31:0] i_request_id,
    input  logic [31:0] i_partition_start,
    input  logic        i_virtual_partitions,
    input  logic [31:0] i_response_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [3:0]  o_segment_index,
    output logic [31:0] o_segment_word,
    output logic [31:0] o_entry_id,
    output logic        o_entry_is_write,
    output logic [31:0] o_entry_sector,
    output logic [15:0] o_entry_device,
    output logic [31:0] o_published_index,
    output logic        o_kick
);
    import brm_pkg::*;

    localparam int SLOT_W = $clog2(RING_SIZE);
    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0]       RING_DEPTH = 32'(RING_SIZE);
    localparam logic [31:0]       RING_HALF  = 32'(RING_SIZE / 2);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RING_SIZE - 1);
    localparam logic [SEG_W-1:0]  SEG_MAX    = SEG_W'(MAX_SEGMENTS);
    localparam logic              RUN_KEEP   = (MAX_SEGMENTS > 1);

    logic [1:0]        r_link, n_link;
    logic [3:0]        r_pbits, n_pbits;
    logic [31:0]       r_produce, n_produce;
    logic [31:0]       r_consume, n_consume;
    logic              r_run_open, n_run_open;
    logic              r_run_wr, n_run_wr;
    logic [15:0]       r_run_dev, n_run_dev;
    logic [31:0]       r_run_next, n_run_next;
    logic [SEG_W-1:0]  r_run_segs, n_run_segs;
    logic [31:0]       r_run_id, n_run_id;
    logic [31:0]       r_run_sector, n_run_sector;
    logic [SLOT_W-1:0] r_prod_slot, n_prod_slot;
    logic [SLOT_W-1:0] r_last_slot, n_last_slot;

    t_result           r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    logic              acc, out_take, cfg_wr;
    t_req_type         req;
    logic [15:0]       dev_m;
    logic [31:0]       abs_sect, occupancy, word;
    logic              match, full;
    logic [SEG_W-1:0]  seg_inc;

    assign acc      = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign req      = t_req_type'(i_req_type);

    assign dev_m     = i_virtual_partitions ? i_device : (i_device & (16'hFFFF << r_pbits));
    assign abs_sect  = i_sector + i_partition_start;
    assign word      = i_buffer_addr | {23'b0, i_sector_count};
    assign occupancy = r_produce - r_consume;
    assign full      = occupancy >= RING_DEPTH;
    assign seg_inc   = r_run_segs + SEG_W'(1);
    assign match     = r_run_open && (r_run_wr == i_is_write) && (r_run_dev == dev_m)
                       && (r_run_next == abs_sect);

    always_comb begin
        n_link       = r_link;
        n_pbits      = r_pbits;
        n_produce    = r_produce;
        n_consume    = r_consume;
        n_run_open   = r_run_open;
        n_run_wr     = r_run_wr;
        n_run_dev    = r_run_dev;
        n_run_next   = r_run_next;
        n_run_segs   = r_run_segs;
        n_run_id     = r_run_id;
        n_run_sector = r_run_sector;
        n_prod_slot  = r_prod_slot;
        n_last_slot  = r_last_slot;
        res          = '0;
        res.status   = ST_NEW;

        unique case (req)
            REQ_CONSUME: begin
                if (r_link == LINK_CLOSED) begin
                    res.status = ST_CLOSED;
                end else begin
                    n_consume = i_response_index;
                    res.kick  = (r_produce - i_response_index) < RING_HALF;
                end
            end
            REQ_PUBLISH: begin
                n_run_open          = 1'b0;
                res.published_index = r_produce;
            end
            REQ_RESET: begin
                n_produce   = '0;
                n_consume   = '0;
                n_run_open  = 1'b0;
                n_link      = LINK_ACTIVE;
                n_prod_slot = '0;
            end
            REQ_SUBMIT: begin
                if ((i_buffer_addr[8:0] & SECT_MASK) != 9'd0) begin
                    res.status = ST_BAD_SEG;
                end else if (r_link == LINK_CLOSED) begin
                    res.status = ST_CLOSED;
                end else if (match) begin
                    n_run_id   = i_request_id;
                    n_run_segs = seg_inc;
                    if (seg_inc < SEG_MAX) begin
                        n_run_next = abs_sect + {23'b0, i_sector_count};
                    end else begin
                        n_run_open = 1'b0;
                    end
                    res.status         = ST_MERGED;
                    res.slot           = 6'(r_last_slot);
                    res.segment_index  = 4'(r_run_segs);
                    res.segment_word   = word;
                    res.entry_id       = i_request_id;
                    res.entry_is_write = r_run_wr;
                    res.entry_sector   = r_run_sector;
                    res.entry_device   = r_run_dev;
                end else if (full || (r_link != LINK_ACTIVE)) begin
                    res.status = ST_FULL;
                end else begin
                    n_run_open   = RUN_KEEP;
                    n_run_wr     = i_is_write;
                    n_run_dev    = dev_m;
                    n_run_next   = abs_sect + {23'b0, i_sector_count};
                    n_run_segs   = SEG_W'(1);
                    n_run_id     = i_request_id;
                    n_run_sector = abs_sect;
                    n_last_slot  = r_prod_slot;
                    n_produce    = r_produce + 32'd1;
                    if (r_produce == 32'hFFFF_FFFF || r_prod_slot == SLOT_LAST) begin
                        n_prod_slot = '0;
                    end else begin
                        n_prod_slot = r_prod_slot + SLOT_W'(1);
                    end
                    res.status         = ST_NEW;
                    res.slot           = 6'(r_prod_slot);
                    res.segment_word   = word;
                    res.entry_id       = i_request_id;
                    res.entry_is_write = i_is_write;
                    res.entry_sector   = abs_sect;
                    res.entry_device   = dev_m;
                end
            end
            default: begin
                res.status = ST_NEW;
            end
        endcase

        if (!acc) begin
            n_link       = r_link;
            n_produce    = r_produce;
            n_consume    = r_consume;
            n_run_open   = r_run_open;
            n_run_wr     = r_run_wr;
            n_run_dev    = r_run_dev;
            n_run_next   = r_run_next;
            n_run_segs   = r_run_segs;
            n_run_id     = r_run_id;
            n_run_sector = r_run_sector;
            n_prod_slot  = r_prod_slot;
            n_last_slot  = r_last_slot;
        end

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_LINK_STATE:     n_link  = pwdata[1:0];
                REG_PARTITION_BITS: n_pbits = pwdata[3:0];
                default:            n_link  = r_link;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link       <= LINK_SUSPENDED;
            r_pbits      <= PBITS_RESET;
            r_produce    <= '0;
            r_consume    <= '0;
            r_run_open   <= 1'b0;
            r_run_wr     <= 1'b0;
            r_run_dev    <= '0;
            r_run_next   <= '0;
            r_run_segs   <= '0;
            r_run_id     <= '0;
            r_run_sector <= '0;
            r_prod_slot  <= '0;
            r_last_slot  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_link       <= n_link;
            r_pbits      <= n_pbits;
            r_produce    <= n_produce;
            r_consume    <= n_consume;
            r_run_open   <= n_run_open;
            r_run_wr     <= n_run_wr;
            r_run_dev    <= n_run_dev;
            r_run_next   <= n_run_next;
            r_run_segs   <= n_run_segs;
            r_run_id     <= n_run_id;
            r_run_sector <= n_run_sector;
            r_prod_slot  <= n_prod_slot;
            r_last_slot  <= n_last_slot;
            if (acc) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (out_take) begin
            r_out <= r_skid;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LINK_STATE:     prdata = {30'b0, r_link};
            REG_PARTITION_BITS: prdata = {28'b0, r_pbits};
            default:            prdata = '0;
        endcase
    end

    assign pready            = 1'b1;
    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_slot            = r_out.slot;
    assign o_segment_index   = r_out.segment_index;
    assign o_segment_word    = r_out.segment_word;
    assign o_entry_id        = r_out.entry_id;
    assign o_entry_is_write  = r_out.entry_is_write;
    assign o_entry_sector    = r_out.entry_sector;
    assign o_entry_device    = r_out.entry_device;
    assign o_published_index = r_out.published_index;
    assign o_kick            = r_out.kick;

    `BRM_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds a beat while output register is empty")
    `BRM_ASSERT_SAME(a_run_segs_range, i_clk, i_rst_n, r_run_open,
        (r_run_segs != '0) && (r_run_segs < SEG_MAX), "open run has bad segment count")
    `BRM_ASSERT_SAME(a_slot_range, i_clk, i_rst_n, 1'b1,
        (r_prod_slot <= SLOT_LAST) && (r_last_slot <= SLOT_LAST), "ring slot out of range")
    `BRM_ASSERT_NEXT(a_merge_keeps_index, i_clk, i_rst_n,
        acc && (req == REQ_SUBMIT) && (res.status == ST_MERGED) && !cfg_wr,
        $stable(r_produce) && $stable(r_prod_slot), "merge moved the producer index")

endmodule
